/* rtl/core/mtep_pkg.sv */
// Package for the MIDI track event parser: result kinds, error codes, constants.
// No dependencies.
package mtep_pkg;

    typedef enum logic [1:0] {
        KIND_NOTE  = 2'd0,
        KIND_TEMPO = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_BAD_VLQ     = 3'd0,
        ERR_NO_RUNNING  = 3'd1,
        ERR_META_END    = 3'd2,
        ERR_BAD_STATUS  = 3'd3,
        ERR_TRUNCATED   = 3'd4
    } err_t;

    localparam logic [7:0]  STATUS_META    = 8'hFF;
    localparam logic [7:0]  STATUS_SYSEX   = 8'hF0;
    localparam logic [7:0]  STATUS_SYSEX_C = 8'hF7;
    localparam logic [7:0]  META_TEMPO     = 8'h51;
    localparam logic [3:0]  CMD_NOTE_OFF   = 4'h8;
    localparam logic [3:0]  CMD_NOTE_ON    = 4'h9;
    localparam logic [3:0]  CMD_PROGRAM    = 4'hC;
    localparam logic [3:0]  CMD_PRESSURE   = 4'hD;
    localparam logic [31:0] BPM_NUMERATOR  = 32'd120000000;
    localparam logic [15:0] TPQ_RESET      = 16'd480;
    localparam logic [25:0] BPM_RESET      = 26'd120;

endpackage

/* rtl/core/midi_track_event_parser.sv */
// MIDI track event parser: byte-stream parse, open-note table, shared divider.
// Depends on mtep_pkg.
//
//  channel   direction  handshake        payload
//  in        sink       in_valid/stall   data_byte, track_start, track_last
//  out       source     out_valid/stall  kind .. error_code
//  cfg       sink       valid/ready      ticks_per_quarter word
//
// A plain byte holds in stall through the parse, end-of-track check and output states,
// so a new byte is taken only once the last is through; a parse error skips the check.
// A note-off scans the open-note table one slot a cycle and, on a match,
// runs two 48-step restoring divides on one shared one-bit-per-cycle divider,
// then compacts the table one slot a cycle. A tempo event runs one 48-step divide.
// Reset clears control state; in stall also holds while a result waits.
module midi_track_event_parser #(
    parameter int OPEN_NOTE_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        track_start,
    input  logic        track_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [47:0] start_quarters,
    output logic [47:0] length_quarters,
    output logic [6:0]  note_pitch,
    output logic [6:0]  note_velocity,
    output logic [25:0] tempo_bpm,
    output logic [2:0]  error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int SW = (OPEN_NOTE_SLOTS > 1) ? $clog2(OPEN_NOTE_SLOTS) : 1;
    localparam int CW = $clog2(OPEN_NOTE_SLOTS + 1);

    typedef enum logic [3:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN,
        PH_META_SKIP, PH_SYSEX_LEN, PH_SYSEX_SKIP, PH_IDLE
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE, S_PARSE, S_SCAN, S_DIV_START, S_DIV_LEN, S_SHIFT,
        S_DIV_TEMPO, S_LAST, S_OUT
    } state_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [15:0] tpq_reg;
    logic [31:0] tick_reg;
    logic [7:0]  rs_reg;
    logic [31:0] vlq_reg;
    logic [2:0]  vlq_n_reg;
    logic [7:0]  meta_reg;
    logic [31:0] skip_reg;
    logic [23:0] tempo_reg;
    logic [6:0]  first_reg;
    logic        err_reg;
    logic [25:0] bpm_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        res_reg;

    logic [6:0]  np_reg [OPEN_NOTE_SLOTS];
    logic [6:0]  nv_reg [OPEN_NOTE_SLOTS];
    logic [31:0] ns_reg [OPEN_NOTE_SLOTS];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [6:0]  off_pitch_reg;
    logic [31:0] off_start_reg;

    logic [47:0] dq_reg;
    logic [48:0] dr_reg;
    logic [47:0] dd_reg;
    logic [5:0]  dc_reg;

    logic [1:0]  kind_reg;
    logic [47:0] sq_reg;
    logic [47:0] lq_reg;
    logic [6:0]  pitch_reg;
    logic [6:0]  vel_reg;
    logic [25:0] tbpm_reg;
    logic [2:0]  ec_reg;
    logic        ov_reg;

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign cfg_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign kind = kind_reg;
    assign start_quarters = sq_reg;
    assign length_quarters = lq_reg;
    assign note_pitch = pitch_reg;
    assign note_velocity = vel_reg;
    assign tempo_bpm = tbpm_reg;
    assign error_code = ec_reg;

    logic [48:0] trial;
    logic [47:0] q_nx;
    logic [48:0] r_nx;
    logic [31:0] vlq_nx;
    logic [2:0]  vlq_n_nx;
    logic [23:0] tempo_nx;
    logic [15:0] tpq_eff;
    logic [31:0] len_ticks;
    logic [3:0]  cmd;

    always_comb
    begin
        tpq_eff  = (tpq_reg == 16'd0) ? 16'd1 : tpq_reg;
        trial    = {dr_reg[47:0], dq_reg[47]} - {1'b0, dd_reg};
        q_nx     = {dq_reg[46:0], !trial[48]};
        r_nx     = trial[48] ? {dr_reg[47:0], dq_reg[47]} : trial;
        vlq_nx   = {vlq_reg[24:0], byte_reg[6:0]};
        vlq_n_nx = vlq_n_reg + 3'd1;
        tempo_nx = {tempo_reg[15:0], byte_reg};
        len_ticks = tick_reg - off_start_reg;
        cmd      = rs_reg[7:4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DELTA;
            tpq_reg   <= mtep_pkg::TPQ_RESET;
            tick_reg  <= '0;
            rs_reg    <= '0;
            vlq_reg   <= '0;
            vlq_n_reg <= '0;
            meta_reg  <= '0;
            skip_reg  <= '0;
            tempo_reg <= '0;
            first_reg <= '0;
            err_reg   <= 1'b0;
            bpm_reg   <= mtep_pkg::BPM_RESET;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            res_reg   <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                        tpq_reg <= cfg_data;
                    if (in_valid && !in_stall)
                    begin
                        byte_reg <= data_byte;
                        last_reg <= track_last;
                        res_reg  <= 1'b0;
                        kind_reg <= mtep_pkg::KIND_NOTE;
                        sq_reg <= '0; lq_reg <= '0; pitch_reg <= '0; vel_reg <= '0;
                        tbpm_reg <= '0; ec_reg <= '0;
                        if (track_start)
                        begin
                            phase_reg <= PH_DELTA; tick_reg <= '0; rs_reg <= '0;
                            vlq_reg <= '0; vlq_n_reg <= '0; meta_reg <= '0;
                            skip_reg <= '0; tempo_reg <= '0; first_reg <= '0;
                            cnt_reg <= '0; err_reg <= 1'b0;
                            state_reg <= S_PARSE;
                        end
                        else if (err_reg || phase_reg == PH_IDLE)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_PARSE;
                    end
                end
                S_PARSE:
                begin
                    case (phase_reg)
                        PH_DELTA, PH_META_LEN, PH_SYSEX_LEN:
                        begin
                            if (byte_reg[7] && vlq_n_nx >= 3'd4)
                            begin
                                res_reg <= 1'b1; err_reg <= 1'b1; phase_reg <= PH_IDLE;
                                kind_reg <= mtep_pkg::KIND_ERROR;
                                ec_reg <= mtep_pkg::ERR_BAD_VLQ;
                                state_reg <= S_OUT;
                            end
                            else if (byte_reg[7])
                            begin
                                vlq_reg <= vlq_nx; vlq_n_reg <= vlq_n_nx;
                                state_reg <= S_LAST;
                            end
                            else
                            begin
                                vlq_reg <= '0; vlq_n_reg <= '0;
                                state_reg <= S_LAST;
                                if (phase_reg == PH_DELTA)
                                begin
                                    tick_reg <= tick_reg + vlq_nx;
                                    phase_reg <= PH_STATUS;
                                end
                                else if (phase_reg == PH_META_LEN)
                                begin
                                    skip_reg <= vlq_nx;
                                    tempo_reg <= '0;
                                    if (vlq_nx == 32'd0)
                                    begin
                                        meta_reg <= '0; phase_reg <= PH_DELTA;
                                    end
                                    else
                                    begin
                                        if (meta_reg != mtep_pkg::META_TEMPO
                                            || vlq_nx != 32'd3)
                                            meta_reg <= '0;
                                        phase_reg <= PH_META_SKIP;
                                    end
                                end
                                else
                                begin
                                    skip_reg <= vlq_nx;
                                    phase_reg <= (vlq_nx != 32'd0) ? PH_SYSEX_SKIP : PH_DELTA;
                                end
                            end
                        end
                        PH_STATUS:
                        begin
                            if (!byte_reg[7])
                            begin
                                if (rs_reg == 8'd0)
                                begin
                                    res_reg <= 1'b1; err_reg <= 1'b1; phase_reg <= PH_IDLE;
                                    kind_reg <= mtep_pkg::KIND_ERROR;
                                    ec_reg <= mtep_pkg::ERR_NO_RUNNING;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    first_reg <= byte_reg[6:0];
                                    if (cmd == mtep_pkg::CMD_PROGRAM
                                        || cmd == mtep_pkg::CMD_PRESSURE)
                                        phase_reg <= PH_DELTA;
                                    else
                                        phase_reg <= PH_DATA2;
                                    state_reg <= S_LAST;
                                end
                            end
                            else if (byte_reg == mtep_pkg::STATUS_META)
                            begin
                                phase_reg <= PH_META_TYPE;
                                state_reg <= S_LAST;
                            end
                            else if (byte_reg == mtep_pkg::STATUS_SYSEX
                                     || byte_reg == mtep_pkg::STATUS_SYSEX_C)
                            begin
                                vlq_reg <= '0; vlq_n_reg <= '0;
                                phase_reg <= PH_SYSEX_LEN;
                                state_reg <= S_LAST;
                            end
                            else if (byte_reg[7:4] == 4'hF)
                            begin
                                res_reg <= 1'b1; err_reg <= 1'b1; phase_reg <= PH_IDLE;
                                kind_reg <= mtep_pkg::KIND_ERROR;
                                ec_reg <= mtep_pkg::ERR_BAD_STATUS;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                rs_reg <= byte_reg;
                                phase_reg <= PH_DATA1;
                                state_reg <= S_LAST;
                            end
                        end
                        PH_DATA1:
                        begin
                            first_reg <= byte_reg[6:0];
                            if (cmd == mtep_pkg::CMD_PROGRAM || cmd == mtep_pkg::CMD_PRESSURE)
                                phase_reg <= PH_DELTA;
                            else
                                phase_reg <= PH_DATA2;
                            state_reg <= S_LAST;
                        end
                        PH_DATA2:
                        begin
                            phase_reg <= PH_DELTA;
                            if (cmd == mtep_pkg::CMD_NOTE_ON && byte_reg[6:0] != 7'd0)
                            begin
                                if (cnt_reg < CW'(OPEN_NOTE_SLOTS))
                                begin
                                    np_reg[cnt_reg[SW-1:0]] <= first_reg;
                                    nv_reg[cnt_reg[SW-1:0]] <= byte_reg[6:0];
                                    ns_reg[cnt_reg[SW-1:0]] <= tick_reg;
                                    cnt_reg <= cnt_reg + CW'(1);
                                end
                                state_reg <= S_LAST;
                            end
                            else if (cmd == mtep_pkg::CMD_NOTE_OFF || cmd == mtep_pkg::CMD_NOTE_ON)
                            begin
                                idx_reg <= '0;
                                off_pitch_reg <= first_reg;
                                state_reg <= S_SCAN;
                            end
                            else
                                state_reg <= S_LAST;
                        end
                        PH_META_TYPE:
                        begin
                            meta_reg <= byte_reg;
                            vlq_reg <= '0; vlq_n_reg <= '0;
                            phase_reg <= PH_META_LEN;
                            state_reg <= S_LAST;
                        end
                        PH_META_SKIP:
                        begin
                            tempo_reg <= tempo_nx;
                            skip_reg <= skip_reg - 32'd1;
                            if (skip_reg == 32'd1)
                            begin
                                phase_reg <= PH_DELTA;
                                meta_reg <= '0;
                            end
                            if (skip_reg == 32'd1 && meta_reg == mtep_pkg::META_TEMPO
                                && tempo_nx != 24'd0)
                            begin
                                dq_reg <= {16'd0, mtep_pkg::BPM_NUMERATOR + {8'd0, tempo_nx}};
                                dd_reg <= {23'd0, tempo_nx, 1'b0};
                                dr_reg <= '0; dc_reg <= '0;
                                state_reg <= S_DIV_TEMPO;
                            end
                            else
                                state_reg <= S_LAST;
                        end
                        PH_SYSEX_SKIP:
                        begin
                            skip_reg <= skip_reg - 32'd1;
                            if (skip_reg == 32'd1)
                                phase_reg <= PH_DELTA;
                            state_reg <= S_LAST;
                        end
                        default:
                        begin
                            phase_reg <= PH_IDLE;
                            state_reg <= S_LAST;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    if (idx_reg >= cnt_reg)
                        state_reg <= S_LAST;
                    else if (np_reg[idx_reg[SW-1:0]] == off_pitch_reg)
                    begin
                        res_reg <= 1'b1;
                        kind_reg <= mtep_pkg::KIND_NOTE;
                        pitch_reg <= off_pitch_reg;
                        vel_reg <= nv_reg[idx_reg[SW-1:0]];
                        off_start_reg <= ns_reg[idx_reg[SW-1:0]];
                        dq_reg <= {ns_reg[idx_reg[SW-1:0]], 16'd0};
                        dd_reg <= {32'd0, tpq_eff};
                        dr_reg <= '0; dc_reg <= '0;
                        state_reg <= S_DIV_START;
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                end
                S_DIV_START, S_DIV_LEN, S_DIV_TEMPO:
                begin
                    if (dc_reg == 6'd47)
                    begin
                        dr_reg <= '0; dc_reg <= '0;
                        if (state_reg == S_DIV_START)
                        begin
                            sq_reg <= q_nx;
                            dq_reg <= {len_ticks, 16'd0};
                            state_reg <= S_DIV_LEN;
                        end
                        else if (state_reg == S_DIV_LEN)
                        begin
                            lq_reg <= q_nx;
                            state_reg <= S_SHIFT;
                        end
                        else
                        begin
                            bpm_reg <= q_nx[25:0];
                            tbpm_reg <= q_nx[25:0];
                            kind_reg <= mtep_pkg::KIND_TEMPO;
                            res_reg <= 1'b1;
                            state_reg <= S_LAST;
                        end
                    end
                    else
                    begin
                        dr_reg <= r_nx;
                        dq_reg <= q_nx;
                        dc_reg <= dc_reg + 6'd1;
                    end
                end
                S_SHIFT:
                begin
                    if (idx_reg + CW'(1) >= cnt_reg)
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                        state_reg <= S_LAST;
                    end
                    else
                    begin
                        np_reg[idx_reg[SW-1:0]] <= np_reg[SW'(idx_reg + CW'(1))];
                        nv_reg[idx_reg[SW-1:0]] <= nv_reg[SW'(idx_reg + CW'(1))];
                        ns_reg[idx_reg[SW-1:0]] <= ns_reg[SW'(idx_reg + CW'(1))];
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_LAST:
                begin
                    state_reg <= S_OUT;
                    if (last_reg)
                    begin
                        phase_reg <= PH_IDLE;
                        if (!res_reg)
                        begin
                            if ((phase_reg == PH_DELTA && vlq_n_reg != 3'd0)
                                || phase_reg == PH_META_LEN || phase_reg == PH_SYSEX_LEN)
                            begin
                                res_reg <= 1'b1; err_reg <= 1'b1;
                                kind_reg <= mtep_pkg::KIND_ERROR;
                                ec_reg <= mtep_pkg::ERR_BAD_VLQ;
                            end
                            else if (phase_reg == PH_META_SKIP && skip_reg != 32'd0)
                            begin
                                res_reg <= 1'b1; err_reg <= 1'b1;
                                kind_reg <= mtep_pkg::KIND_ERROR;
                                ec_reg <= mtep_pkg::ERR_META_END;
                            end
                            else if (phase_reg == PH_DATA1 || phase_reg == PH_DATA2)
                            begin
                                res_reg <= 1'b1; err_reg <= 1'b1;
                                kind_reg <= mtep_pkg::KIND_ERROR;
                                ec_reg <= mtep_pkg::ERR_TRUNCATED;
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        ov_reg <= res_reg;
                        res_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
